### hw/rtl/disk_temperature_trend_predictor_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef DISK_TEMPERATURE_TREND_PREDICTOR_MACROS_SVH
`define DISK_TEMPERATURE_TREND_PREDICTOR_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define DTTP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define DTTP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/dttp_pkg.sv
package dttp_pkg;

    localparam int NUM_DISKS_DEF = 4;

    localparam int LEN_W  = 12;
    localparam int THR_W  = 15;
    localparam int ACT_W  = 3;
    localparam int TEMP_W = 16;
    localparam int DISK_W = 2;
    localparam int SUM_W  = 28;
    localparam int DIV_W  = 32;   // divider dividend width
    localparam int DVS_W  = 12;   // divider divisor width
    localparam int CFG_W  = 15;

    localparam logic [LEN_W-1:0] LEN_RST = 12'd600;
    localparam logic [THR_W-1:0] THR_RST = 15'd38;
    localparam logic [ACT_W-1:0] ACT_RST = 3'd3;

    // fast-response term: d0 * |a - p| * 4 / 640 = prod / 160 = (prod >> 5) / 5;
    // ceil(2^34 / 5), exact divide by 5 for operands below 2^34
    localparam logic [31:0] DIV5_RECIP = 32'hCCCCCCCD;

    typedef enum logic [1:0] {
        REG_LEN     = 2'd0,
        REG_THR     = 2'd1,
        REG_PRED_EN = 2'd2,
        REG_ACTIVE  = 2'd3
    } dttp_reg_t;

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_LEARN   = 2'd1,
        PH_PREDICT = 2'd2
    } dttp_phase_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sum;
        logic [LEN_W-1:0]         count;
        dttp_phase_t              phase;
        logic signed [TEMP_W-1:0] last;
        logic signed [TEMP_W-1:0] older;
        logic signed [TEMP_W-1:0] pred;
        logic signed [TEMP_W-1:0] endp;
    } dttp_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_DIV_AVG,
        ST_WAIT_AVG,
        ST_PHASE,
        ST_MUL,
        ST_DIV_TERM,
        ST_WAIT_TERM,
        ST_SMOOTH,
        ST_SER_INIT,
        ST_SERIES,
        ST_WRITE,
        ST_EMIT
    } dttp_state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic div_avg;
        logic take_avg;
        logic phase;
        logic mul;
        logic div_term;
        logic take_term;
        logic smooth;
        logic ser_init;
        logic ser_step;
        logic emit;
        logic write;
    } dttp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic complete;
        logic first;
        logic learn;
        logic jump;
        logic ep_hit;
        logic ser_zero;
        logic div_done;
        logic out_free;
    } dttp_sts_t;

    function automatic logic signed [TEMP_W-1:0] sat16(input logic signed [35:0] v);
        logic signed [TEMP_W-1:0] r;
        if (v > 36'sd32767)
            r = 16'sh7FFF;
        else if (v < -36'sd32768)
            r = -16'sh8000;
        else
            r = TEMP_W'(v);
        return r;
    endfunction

    // trunc(m * 4 / 5) via reciprocal; exact for 4*m below 2^22
    function automatic logic [16:0] div5x4(input logic [16:0] m);
        logic [38:0] prod;
        prod = 39'({m, 2'b00}) * 39'(20'hCCCCD);
        return 17'(prod >> 22);
    endfunction

endpackage

### hw/rtl/dttp_divider.sv
`include "disk_temperature_trend_predictor_macros.svh"

module dttp_divider
    import dttp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic             ge;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNT_W'(DIV_W);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            rem_next  = ge ? DVS_W'(shifted - {1'b0, dvs_reg}) : DVS_W'(shifted);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `DTTP_ASSERT_IMP(a_div_no_restart, start, cnt_reg == '0, "divider restarted while busy")

endmodule

### hw/rtl/dttp_ctrl.sv
module dttp_ctrl
    import dttp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dttp_sts_t sts,
    output dttp_cmd_t cmd
);

    dttp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid && sts.in_range) state_next = ST_LOAD;
            ST_LOAD:      state_next = ST_CHECK;
            ST_CHECK:     state_next = sts.complete ? ST_DIV_AVG : ST_WRITE;
            ST_DIV_AVG:   state_next = ST_WAIT_AVG;
            ST_WAIT_AVG:  if (sts.div_done) state_next = ST_PHASE;
            ST_PHASE:
            begin
                if (sts.first || sts.learn)
                    state_next = ST_EMIT;
                else if (sts.jump)
                    state_next = ST_MUL;
                else
                    state_next = ST_SMOOTH;
            end
            ST_MUL:       state_next = ST_DIV_TERM;
            ST_DIV_TERM:  state_next = ST_WAIT_TERM;
            ST_WAIT_TERM: state_next = ST_SER_INIT;
            ST_SMOOTH:    state_next = sts.ep_hit ? ST_SER_INIT : ST_EMIT;
            ST_SER_INIT:  state_next = ST_SERIES;
            ST_SERIES:    if (sts.ser_zero) state_next = ST_EMIT;
            ST_WRITE:     state_next = ST_IDLE;
            ST_EMIT:      if (sts.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD:      cmd.load      = 1'b1;
            ST_DIV_AVG:   cmd.div_avg   = 1'b1;
            ST_WAIT_AVG:  cmd.take_avg  = sts.div_done;
            ST_PHASE:     cmd.phase     = 1'b1;
            ST_MUL:       cmd.mul       = 1'b1;
            ST_DIV_TERM:  cmd.div_term  = 1'b1;
            ST_WAIT_TERM: cmd.take_term = 1'b1;
            ST_SMOOTH:    cmd.smooth    = 1'b1;
            ST_SER_INIT:  cmd.ser_init  = 1'b1;
            ST_SERIES:    cmd.ser_step  = 1'b1;
            ST_WRITE:     cmd.write     = 1'b1;
            ST_EMIT:
            begin
                cmd.emit  = sts.out_free;
                cmd.write = sts.out_free;
            end
            default:      cmd = '0;
        endcase
    end

endmodule

### hw/rtl/dttp_datapath.sv
`include "disk_temperature_trend_predictor_macros.svh"

module dttp_datapath
    import dttp_pkg::*;
#(
    parameter int NUM_DISKS = NUM_DISKS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dttp_cmd_t          cmd,
    output dttp_sts_t          sts,
    input  logic [DISK_W-1:0]  in_disk,
    input  logic [TEMP_W-1:0]  in_temp,
    input  logic [LEN_W-1:0]   cfg_len,
    input  logic [THR_W-1:0]   cfg_thr,
    input  logic               cfg_pred_en,
    input  logic [ACT_W-1:0]   cfg_active,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DISK_W-1:0]  out_disk,
    output logic [TEMP_W-1:0]  out_avg,
    output logic [TEMP_W-1:0]  out_pred,
    output logic [TEMP_W-1:0]  out_endp,
    output logic               out_fast
);

    localparam int IW = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;

    // per-disk state memory; valid bit clear reads as all-zero entry
    dttp_entry_t          ent_mem [NUM_DISKS];
    logic [NUM_DISKS-1:0] valid_reg;
    dttp_entry_t          rd_reg;
    logic                 rd_vld_reg;

    logic [DISK_W-1:0]        idx_reg;
    logic signed [TEMP_W-1:0] smp_reg;
    dttp_entry_t              ent_reg, ent_next, ent_ld;
    logic signed [TEMP_W-1:0] a_reg;
    logic signed [16:0]       d0_reg, d1_reg;
    logic signed [34:0]       prod_reg;
    logic signed [35:0]       term_reg;
    logic                     fast_reg;
    logic                     div_neg_reg;
    logic [16:0]              k_reg;
    logic                     ser_neg_reg;
    logic signed [21:0]       j_reg;

    logic                 outv_reg;
    logic [DISK_W-1:0]    od_reg;
    logic [TEMP_W-1:0]    oa_reg, op_reg, oe_reg;
    logic                 of_reg;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dvd;
    logic [DVS_W-1:0]     div_dvs;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic signed [32:0]   q_s;

    logic [31:0]          prod_mag;
    logic [58:0]          term_prod;
    logic [26:0]          term_q;

    logic [LEN_W-1:0]     len_eff;
    logic signed [17:0]   a18, p18, e18, t18;
    logic [16:0]          diff17;
    logic signed [34:0]   prod_full;
    logic signed [19:0]   d0x5, d1x3;
    logic                 smooth_ok;
    logic [16:0]          d0_mag, d0_red;
    logic signed [35:0]   d0_red_s;

    // --- memory ---
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rd_reg <= ent_mem[IW'(in_disk)];
        if (cmd.write)
            ent_mem[IW'(idx_reg)] <= ent_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
                rd_vld_reg <= valid_reg[IW'(in_disk)];
            if (cmd.write)
                valid_reg[IW'(idx_reg)] <= 1'b1;
        end
    end

    // --- divider (interval average) ---
    assign div_start = cmd.div_avg;
    assign div_dvd   = DIV_W'(ent_reg.sum < 0 ? -ent_reg.sum : ent_reg.sum);
    assign div_dvs   = ent_reg.count;

    dttp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign q_s = div_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    // --- fast-response term: trunc(prod / 160) as ((|prod| >> 5) / 5) by reciprocal ---
    assign prod_mag  = 32'(prod_reg < 0 ? -prod_reg : prod_reg);
    assign term_prod = 59'(prod_mag[31:5]) * 59'(DIV5_RECIP);
    assign term_q    = 27'(term_prod >> 34);

    // --- comparisons and helpers ---
    assign len_eff = (cfg_len == '0) ? LEN_W'(1) : cfg_len;
    assign a18     = 18'(a_reg);
    assign p18     = 18'(ent_reg.pred);
    assign e18     = 18'(ent_reg.endp);
    assign t18     = $signed({3'b000, cfg_thr});
    assign diff17  = (a18 > p18) ? 17'(a18 - p18) : 17'(p18 - a18);
    assign prod_full = d0_reg * $signed({1'b0, diff17});

    assign d0x5 = 20'(d0_reg) * 20'sd5;
    assign d1x3 = 20'(d1_reg) * 20'sd3;
    assign smooth_ok = ((d1_reg > 0) && (d1x3 < d0x5) && (d0_reg < d1_reg)) ||
                       ((d1_reg < 0) && (d0_reg > d1_reg) && (d0x5 < d1x3));
    assign d0_mag   = 17'(d0_reg < 0 ? -d0_reg : d0_reg);
    assign d0_red   = div5x4(d0_mag);
    assign d0_red_s = (d0_reg < 0) ? -36'($signed({1'b0, d0_red}))
                                   :  36'($signed({1'b0, d0_red}));

    always_comb
    begin
        sts.in_range = (32'(in_disk) < 32'(cfg_active)) && (32'(in_disk) < NUM_DISKS);
        sts.complete = ent_reg.count >= len_eff;
        sts.first    = ent_reg.phase == PH_FIRST;
        sts.learn    = (ent_reg.phase == PH_LEARN) && !cfg_pred_en;
        sts.jump     = (a18 > p18 + t18) || (a18 + t18 < p18);
        sts.ep_hit   = ((d0_reg < 0) && (a18 + t18 < e18)) ||
                       ((d0_reg > 0) && (a18 > e18 + t18));
        sts.ser_zero = k_reg == '0;
        sts.div_done = div_done;
        sts.out_free = !outv_reg || out_ready;
    end

    // --- entry update ---
    always_comb
    begin
        ent_ld       = rd_vld_reg ? rd_reg : '0;
        ent_ld.sum   = ent_ld.sum + SUM_W'(smp_reg);
        ent_ld.count = ent_ld.count + 1'b1;

        ent_next = ent_reg;
        if (cmd.load)
            ent_next = ent_ld;
        if (cmd.phase)
        begin
            ent_next.sum   = '0;
            ent_next.count = '0;
            case (ent_reg.phase)
                PH_FIRST:
                begin
                    ent_next.older = a_reg;
                    ent_next.pred  = a_reg;
                    ent_next.endp  = a_reg;
                    ent_next.phase = PH_LEARN;
                end
                default:
                begin
                    if ((ent_reg.phase == PH_LEARN) && !cfg_pred_en)
                    begin
                        ent_next.last = a_reg;
                        ent_next.pred = a_reg;
                        ent_next.endp = a_reg;
                    end
                    else
                    begin
                        ent_next.phase = PH_PREDICT;
                        ent_next.older = ent_reg.last;
                        ent_next.last  = a_reg;
                    end
                end
            endcase
        end
        if (cmd.take_term)
            ent_next.pred = sat16(36'(a_reg) + term_reg);
        if (cmd.smooth)
            ent_next.pred = smooth_ok ? sat16(36'(a_reg) + d0_red_s) : a_reg;
        if (cmd.ser_step && (k_reg == '0))
            ent_next.endp = sat16(36'(j_reg));
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        if (cmd.capture)
        begin
            idx_reg <= in_disk;
            smp_reg <= $signed(in_temp);
        end
        if (div_start)
            div_neg_reg <= ent_reg.sum < 0;
        if (cmd.take_avg)
            a_reg <= TEMP_W'(q_s);
        if (cmd.phase)
        begin
            d0_reg   <= 17'(a_reg) - 17'(ent_reg.last);
            d1_reg   <= 17'(ent_reg.last) - 17'(ent_reg.older);
            fast_reg <= 1'b0;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full;
            fast_reg <= 1'b1;
        end
        if (cmd.div_term)
            term_reg <= (prod_reg < 0) ? -36'($signed({1'b0, term_q}))
                                       :  36'($signed({1'b0, term_q}));
        // series: j starts at a - d0 so each step adds the current term
        if (cmd.ser_init)
        begin
            k_reg       <= d0_mag;
            ser_neg_reg <= d0_reg < 0;
            j_reg       <= 22'(ent_reg.older);
        end
        else if (cmd.ser_step && (k_reg != '0))
        begin
            k_reg <= div5x4(k_reg);
            j_reg <= ser_neg_reg ? j_reg - 22'($signed({1'b0, k_reg}))
                                 : j_reg + 22'($signed({1'b0, k_reg}));
        end
    end

    // --- output register ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outv_reg <= 1'b0;
        else if (cmd.emit)
            outv_reg <= 1'b1;
        else if (out_ready)
            outv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            od_reg <= idx_reg;
            oa_reg <= a_reg;
            op_reg <= ent_reg.pred;
            oe_reg <= ent_reg.endp;
            of_reg <= fast_reg;
        end
    end

    assign out_valid = outv_reg;
    assign out_disk  = od_reg;
    assign out_avg   = oa_reg;
    assign out_pred  = op_reg;
    assign out_endp  = oe_reg;
    assign out_fast  = of_reg;

    `DTTP_ASSERT_NXT(a_series_shrinks, cmd.ser_step && (k_reg != '0), k_reg < $past(k_reg), "series term did not shrink")
    `DTTP_ASSERT_IMP(a_avg_nonzero_count, cmd.div_avg, ent_reg.count != '0, "average with empty interval")
    `DTTP_ASSERT_IMP(a_avg_in_range, cmd.take_avg, div_quo <= DIV_W'(32768), "interval average out of range")

endmodule

### hw/rtl/disk_temperature_trend_predictor.sv
// Disk temperature trend predictor. Each input transaction carries one
// temperature sample (signed, 1/128 degree) for one disk, selected by s_tuser.
// Samples are summed per disk; when a disk's interval_len samples are in,
// one output transaction gives the interval average, the updated prediction,
// the endpoint forecast and a fast-response flag. Samples for disks at or
// above active_disks are accepted and dropped. When an interval closes, the
// bit-serial divider forms the average; when predicting, the jump term divides
// by 160 with a reciprocal multiply and the endpoint series adds one 0.8 term
// per step. A closing sample also waits while the previous result is still
// held in the output register. One sample is processed at a time; a finished
// result waits in the output register while the next sample is taken.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module disk_temperature_trend_predictor
    import dttp_pkg::*;
#(
    parameter int NUM_DISKS = NUM_DISKS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    // config write port
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] sample_temp
    input  logic [1:0]        s_tuser,   // [1:0] disk_index

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // [15:0] interval_avg, [31:16] predicted_temp,
                                         // [47:32] endpoint_temp
    output logic [2:0]        m_tuser    // [1:0] out_disk, [2] fast_response
);

    // configuration registers
    logic [LEN_W-1:0] len_reg;
    logic [THR_W-1:0] thr_reg;
    logic             pen_reg;
    logic [ACT_W-1:0] act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RST;
            thr_reg <= THR_RST;
            pen_reg <= 1'b0;
            act_reg <= ACT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (dttp_reg_t'(cfg_addr))
                REG_LEN:     len_reg <= cfg_wdata[LEN_W-1:0];
                REG_THR:     thr_reg <= cfg_wdata[THR_W-1:0];
                REG_PRED_EN: pen_reg <= cfg_wdata[0];
                REG_ACTIVE:  act_reg <= cfg_wdata[ACT_W-1:0];
                default:     len_reg <= len_reg;
            endcase
        end
    end

    dttp_cmd_t cmd;
    dttp_sts_t sts;

    logic [TEMP_W-1:0] o_avg, o_pred, o_endp;
    logic [DISK_W-1:0] o_disk;
    logic              o_fast;

    // sequencer: one sample at a time through the states
    dttp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // per-disk state, divider, series unit and output register
    dttp_datapath #(
        .NUM_DISKS (NUM_DISKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_disk     (s_tuser),
        .in_temp     (s_tdata),
        .cfg_len     (len_reg),
        .cfg_thr     (thr_reg),
        .cfg_pred_en (pen_reg),
        .cfg_active  (act_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_disk    (o_disk),
        .out_avg     (o_avg),
        .out_pred    (o_pred),
        .out_endp    (o_endp),
        .out_fast    (o_fast)
    );

    assign m_tdata = {o_endp, o_pred, o_avg};
    assign m_tuser = {o_fast, o_disk};

endmodule

### bench/disk_temperature_trend_predictor_test.sv
`timescale 1ns / 1ps

module disk_temperature_trend_predictor_test;
    import dttp_pkg::*;

    // one interval result as the block reports it
    typedef struct {
        logic [1:0]         disk;
        logic signed [15:0] avg;
        logic signed [15:0] pred;
        logic signed [15:0] endp;
        logic               fast;
    } interval_result_t;

    typedef enum {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    // one line of the directed part: either a register write or a sample,
    // with the result typed in where it is obvious
    typedef struct {
        row_kind_t        kind;
        dttp_reg_t        addr;
        int               value;
        int               disk;
        int               temp;
        bit               typed;
        interval_result_t res;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [1:0]        cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;   // [15:0] sample_temp
    logic [1:0]        s_tuser;   // [1:0] disk_index
    logic              m_tvalid;
    logic              m_tready;
    logic [47:0]       m_tdata;   // [15:0] interval_avg, [31:16] predicted_temp,
                                  // [47:32] endpoint_temp
    logic [2:0]        m_tuser;   // [1:0] out_disk, [2] fast_response

    disk_temperature_trend_predictor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: registers and per-disk history
    // ------------------------------------------------------------------
    int                 len_reg;
    int                 thr_reg;
    int                 pred_on;
    int                 active_reg;

    logic signed [27:0] acc_sum  [4];
    int                 acc_cnt  [4];
    dttp_phase_t        phase_of [4];
    logic signed [15:0] last_of  [4];
    logic signed [15:0] older_of [4];
    logic signed [15:0] pred_of  [4];
    logic signed [15:0] endp_of  [4];

    interval_result_t   pending_results[$];

    int  errors;
    int  results_seen;
    int  samples_ignored;
    int  jumps_seen;
    int  saturated_seen;
    bit  no_gaps;           // a phase with back-to-back transactions
    bit  sink_running;

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return -16'sh8000;
        return 16'(v);
    endfunction

    // endpoint: a plus the 0.8-geometric series of d0, until a term truncates to 0
    function automatic logic signed [15:0] endpoint_series(int a, int d0);
        longint k;
        longint j;
        k = d0;
        j = a;
        while (k != 0)
        begin
            k = (k * 4) / 5;
            j += k;
        end
        return clamp16(j);
    endfunction

    task automatic write_reg(dttp_reg_t addr, int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (addr)
            REG_LEN:     len_reg    = value & 12'hFFF;
            REG_THR:     thr_reg    = value & 15'h7FFF;
            REG_PRED_EN: pred_on    = value & 1;
            REG_ACTIVE:  active_reg = value & 7;
            default:     ;
        endcase
    endtask

    // Folds one accepted sample into the shadow state; returns 1 when the
    // disk's interval closes and fills in the result.
    function automatic bit fold_sample(int d, int s, output interval_result_t r);
        int lim;
        int len;
        int a;
        int d0;
        int d1;
        int p;
        longint gap;
        bit smooth;
        lim = (active_reg < 4) ? active_reg : 4;
        len = (len_reg != 0) ? len_reg : 1;
        r.fast = 1'b0;
        if (d >= lim)
        begin
            samples_ignored++;
            return 0;
        end
        acc_sum[d] = 28'(acc_sum[d] + s);
        acc_cnt[d]++;
        // shortened interval: count may already be past a lowered length
        if (acc_cnt[d] < len)
            return 0;
        a = int'(acc_sum[d]) / acc_cnt[d];
        acc_sum[d] = '0;
        acc_cnt[d] = 0;
        if (phase_of[d] == PH_FIRST)
        begin
            older_of[d] = 16'(a);
            pred_of[d]  = 16'(a);
            endp_of[d]  = 16'(a);
            phase_of[d] = PH_LEARN;
        end
        else if (phase_of[d] == PH_LEARN && pred_on == 0)
        begin
            last_of[d] = 16'(a);
            pred_of[d] = 16'(a);
            endp_of[d] = 16'(a);
        end
        else
        begin
            // once predicting, a disk never goes back to learning
            phase_of[d] = PH_PREDICT;
            d0 = a - last_of[d];
            d1 = int'(last_of[d]) - int'(older_of[d]);
            p  = pred_of[d];
            older_of[d] = last_of[d];
            last_of[d]  = 16'(a);
            if (a > p + thr_reg || a + thr_reg < p)
            begin
                gap = (a > p) ? longint'(a) - p : longint'(p) - a;
                pred_of[d] = clamp16(longint'(a) + (longint'(d0) * gap * 4) / 640);
                endp_of[d] = endpoint_series(a, d0);
                r.fast = 1'b1;
            end
            else
            begin
                smooth = 0;
                if (d1 > 0)
                    smooth = (3 * d1 < 5 * d0) && (d0 < d1);
                else if (d1 < 0)
                    smooth = (d0 > d1) && (5 * d0 < 3 * d1);
                pred_of[d] = smooth ? clamp16(longint'(a) + (longint'(d0) * 4) / 5)
                                    : 16'(a);
                if ((d0 < 0 && a + thr_reg < endp_of[d]) ||
                    (d0 > 0 && a > endp_of[d] + thr_reg))
                    endp_of[d] = endpoint_series(a, d0);
            end
        end
        r.disk = 2'(d);
        r.avg  = 16'(a);
        r.pred = pred_of[d];
        r.endp = endp_of[d];
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Drives one sample transaction; the expectation is queued at acceptance.
    task automatic send_sample(int d, int t, bit typed, interval_result_t typed_res);
        int gap;
        interval_result_t r;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= 2'(d);
        s_tdata  <= 16'(t);
        do
            @(posedge clk);
        while (!s_tready);
        if (fold_sample(d, 16'sh0 + $signed(16'(t)), r))
            pending_results.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    // Block must be idle before a register write: all results in, and then
    // enough cycles for any non-closing sample still in flight.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #3ms;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink with random back-pressure
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        interval_result_t want;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            if (m_tuser[2])
                jumps_seen++;
            if (pending_results.size() == 0)
                report_mismatch("queued results at output transaction", 0, 1);
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser[1:0] != want.disk)
                    report_mismatch("out_disk", m_tuser[1:0], want.disk);
                if ($signed(m_tdata[15:0]) != want.avg)
                    report_mismatch("interval_avg", $signed(m_tdata[15:0]), want.avg);
                if ($signed(m_tdata[31:16]) != want.pred)
                    report_mismatch("predicted_temp", $signed(m_tdata[31:16]), want.pred);
                if ($signed(m_tdata[47:32]) != want.endp)
                    report_mismatch("endpoint_temp", $signed(m_tdata[47:32]), want.endp);
                if (m_tuser[2] != want.fast)
                    report_mismatch("fast_response", m_tuser[2], want.fast);
                if (want.pred == 16'sh7FFF || want.pred == -16'sh8000 ||
                    want.endp == 16'sh7FFF || want.endp == -16'sh8000)
                    saturated_seen++;
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        stim_row_t        directed[$];
        stim_row_t        row;
        interval_result_t none;
        int               sent;
        int               level[4];
        int               slope[4];
        int               d;
        int               t;
        int               n;
        int               pick;

        errors          = 0;
        results_seen    = 0;
        samples_ignored = 0;
        jumps_seen      = 0;
        saturated_seen  = 0;
        no_gaps         = 0;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = REG_LEN;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        len_reg    = 600;
        thr_reg    = 38;
        pred_on    = 0;
        active_reg = 3;
        for (int i = 0; i < 4; i++)
        begin
            acc_sum[i]  = '0;
            acc_cnt[i]  = 0;
            phase_of[i] = PH_FIRST;
            last_of[i]  = '0;
            older_of[i] = '0;
            pred_of[i]  = '0;
            endp_of[i]  = '0;
        end
        none = '{disk: 2'd0, avg: '0, pred: '0, endp: '0, fast: 1'b0};

        // --- directed table ---
        row = '{kind: ROW_CFG, addr: REG_LEN, value: 0, disk: 0, temp: 0,
                typed: 0, res: none};
        row.value = 1;                           directed.push_back(row);
        row.addr = REG_ACTIVE;  row.value = 4;   directed.push_back(row);
        row.kind = ROW_SAMPLE;
        // first intervals: everything equals the sample, full-scale corners
        row.typed = 1;
        row.disk = 0; row.temp = 32767;
        row.res = '{2'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}; directed.push_back(row);
        row.disk = 1; row.temp = -32768;
        row.res = '{2'd1, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0}; directed.push_back(row);
        row.disk = 2; row.temp = 0;
        row.res = '{2'd2, 16'sh0, 16'sh0, 16'sh0, 1'b0};         directed.push_back(row);
        row.disk = 3; row.temp = 1;
        row.res = '{2'd3, 16'sh1, 16'sh1, 16'sh1, 1'b0};         directed.push_back(row);
        // learning with prediction off just takes the average
        row.disk = 0; row.temp = 100;
        row.res = '{2'd0, 16'sd100, 16'sd100, 16'sd100, 1'b0};   directed.push_back(row);
        row.typed = 0;
        row.kind = ROW_CFG; row.addr = REG_PRED_EN; row.value = 1; directed.push_back(row);
        row.kind = ROW_SAMPLE;
        // jump, then a steady fall that may take the smoothed path
        row.disk = 0; row.temp = 300;    directed.push_back(row);
        row.disk = 0; row.temp = 250;    directed.push_back(row);
        row.disk = 0; row.temp = 220;    directed.push_back(row);
        row.disk = 0; row.temp = 200;    directed.push_back(row);
        // full-scale swings saturate prediction and endpoint
        row.disk = 1; row.temp = 32767;  directed.push_back(row);
        row.disk = 1; row.temp = -32768; directed.push_back(row);
        row.kind = ROW_CFG; row.addr = REG_THR; row.value = 0;     directed.push_back(row);
        row.kind = ROW_SAMPLE;
        row.disk = 2; row.temp = 5;      directed.push_back(row);
        row.disk = 2; row.temp = 5;      directed.push_back(row);
        row.kind = ROW_CFG; row.addr = REG_THR; row.value = 32767; directed.push_back(row);
        row.kind = ROW_SAMPLE;
        row.disk = 3; row.temp = -20000; directed.push_back(row);
        row.disk = 3; row.temp = 20000;  directed.push_back(row);
        // out-of-range disks are dropped; zero and oversized counts
        row.kind = ROW_CFG; row.addr = REG_ACTIVE; row.value = 0;  directed.push_back(row);
        row.kind = ROW_SAMPLE; row.disk = 0; row.temp = 7;         directed.push_back(row);
        row.kind = ROW_CFG; row.addr = REG_ACTIVE; row.value = 7;  directed.push_back(row);
        row.kind = ROW_SAMPLE; row.disk = 3; row.temp = 9;         directed.push_back(row);
        row.kind = ROW_CFG; row.addr = REG_ACTIVE; row.value = 2;  directed.push_back(row);
        row.kind = ROW_SAMPLE; row.disk = 3; row.temp = 9;         directed.push_back(row);
        row.kind = ROW_CFG; row.addr = REG_LEN; row.value = 0;     directed.push_back(row);
        row.kind = ROW_SAMPLE; row.disk = 0; row.temp = -3;        directed.push_back(row);
        row.kind = ROW_CFG; row.addr = REG_LEN; row.value = 4095;  directed.push_back(row);
        row.kind = ROW_SAMPLE; row.disk = 1; row.temp = 1234;      directed.push_back(row);
        row.disk = 1; row.temp = -77;                              directed.push_back(row);
        row.disk = 1; row.temp = 32767;                            directed.push_back(row);
        // lowering the length below the count already held closes at once
        row.kind = ROW_CFG; row.addr = REG_LEN; row.value = 2;     directed.push_back(row);
        row.kind = ROW_SAMPLE; row.disk = 1; row.temp = 32767;     directed.push_back(row);
        // turning prediction off later leaves a predicting disk predicting
        row.kind = ROW_CFG; row.addr = REG_PRED_EN; row.value = 0; directed.push_back(row);
        row.kind = ROW_SAMPLE; row.disk = 1; row.temp = 100;       directed.push_back(row);
        row.disk = 1; row.temp = 100;                              directed.push_back(row);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                drain_block();
                write_reg(directed[i].addr, directed[i].value);
            end
            else
                send_sample(directed[i].disk, directed[i].temp,
                            directed[i].typed, directed[i].res);
        end

        // --- random phases: trending temperatures with noise and jumps ---
        sent = 0;
        while (sent < 1400)
        begin
            drain_block();
            no_gaps = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            write_reg(REG_LEN, (pick == 0) ? $urandom_range(0, 4095) :
                               (pick < 3) ? $urandom_range(7, 40) : $urandom_range(1, 6));
            pick = $urandom_range(0, 5);
            write_reg(REG_THR, (pick == 0) ? 0 : (pick == 1) ? 32767 :
                               (pick == 2) ? $urandom_range(0, 32767) : $urandom_range(0, 120));
            write_reg(REG_PRED_EN, ($urandom_range(0, 3) != 0));
            pick = $urandom_range(0, 9);
            write_reg(REG_ACTIVE, (pick == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4));
            for (int i = 0; i < 4; i++)
            begin
                level[i] = $urandom_range(0, 12000) - 6000;
                slope[i] = $urandom_range(0, 40) - 20;
            end
            n = $urandom_range(30, 90);
            repeat (n)
            begin
                d = $urandom_range(0, 3);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    t = $signed(16'($urandom()));            // raw noise, all bits
                else if (pick == 1)
                    t = $urandom_range(0, 1) ? 32767 : -32768;
                else
                begin
                    if (pick == 2)
                        level[d] += $urandom_range(0, 8000) - 4000;
                    level[d] += slope[d];
                    if (level[d] > 32767)
                        level[d] = 32767;
                    if (level[d] < -32768)
                        level[d] = -32768;
                    t = level[d] + $urandom_range(0, 6) - 3;
                    if (t > 32767)
                        t = 32767;
                    if (t < -32768)
                        t = -32768;
                end
                send_sample(d, t, 0, none);
                sent++;
            end
        end

        // every expected result in, then let the block settle
        drain_block();
        $display("Run: %0d random samples after the directed table, %0d results checked,",
                 sent, results_seen);
        $display("     %0d fast-response, %0d saturated, %0d samples dropped as out of range",
                 jumps_seen, saturated_seen, samples_ignored);
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
